>>> rtl/tree_path_min_query_macros.svh
// Assertion helpers for the path-minimum block.
`ifndef TREE_PATH_MIN_QUERY_MACROS_SVH
`define TREE_PATH_MIN_QUERY_MACROS_SVH

// Same-cycle implication, held off during reset.
`define TPMQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define TPMQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tpmq_pkg.sv
// ---------------------------------------------------------------------------
// tpmq_pkg
// Shared constants, opcodes and table port types for the path-minimum block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpmq_pkg;

    localparam int MAX_NODES = 1024;
    localparam int LEVELS    = 10;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int LVL_W     = $clog2(LEVELS + 1);
    localparam int TAB_DEPTH = MAX_NODES * LEVELS;
    localparam int ADDR_W    = $clog2(TAB_DEPTH);
    localparam int CNT_W     = 11;
    localparam int DEP_W     = 10;
    localparam int W_W       = 20;

    localparam logic [W_W-1:0] EMPTY_PATH = W_W'(1000001);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    typedef struct packed {
        logic              tab_en;
        logic [ADDR_W-1:0] tab_addr;
        logic [NODE_W-1:0] anc_data;
        logic [W_W-1:0]    min_data;
        logic              dep_en;
        logic [NODE_W-1:0] dep_addr;
        logic [DEP_W-1:0]  dep_data;
    } tab_wr_t;

    typedef struct packed {
        logic [ADDR_W-1:0] tab_addr;
        logic [NODE_W-1:0] dep_addr;
    } tab_rd_t;

    function automatic logic [ADDR_W-1:0] tab_index(input logic [NODE_W-1:0] node,
                                                    input logic [LVL_W-1:0] lvl);
        return ADDR_W'(int'(node) * LEVELS + int'(lvl));
    endfunction

endpackage

>>> rtl/tpmq_tables.sv
// ---------------------------------------------------------------------------
// tpmq_tables
// Ancestor, minimum and depth tables; one write and one registered read each.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpmq_tables
    import tpmq_pkg::*;
(
    input  logic              aclk,
    input  tab_wr_t           wr,
    input  tab_rd_t           rd,
    output logic [NODE_W-1:0] anc_rdata,
    output logic [W_W-1:0]    min_rdata,
    output logic [DEP_W-1:0]  dep_rdata
);

    logic [NODE_W-1:0] anc_mem [TAB_DEPTH];
    logic [W_W-1:0]    min_mem [TAB_DEPTH];
    logic [DEP_W-1:0]  dep_mem [MAX_NODES];

    always_ff @(posedge aclk) begin
        if (wr.tab_en) begin
            anc_mem[wr.tab_addr] <= wr.anc_data;
            min_mem[wr.tab_addr] <= wr.min_data;
        end
        if (wr.dep_en) begin
            dep_mem[wr.dep_addr] <= wr.dep_data;
        end
        anc_rdata <= anc_mem[rd.tab_addr];
        min_rdata <= min_mem[rd.tab_addr];
        dep_rdata <= dep_mem[rd.dep_addr];
    end

endmodule

>>> rtl/tree_path_min_query.sv
// ---------------------------------------------------------------------------
// tree_path_min_query
// Tree path minimum edge weight by binary lifting, with a table sequencer.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tuser opcode, tdata node_a/node_b/weight
//  m_      | out | m_tvalid/m_tready  | tdata path_minimum
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data node_count
//
//  Every step goes through the single registered read port of the tables,
//  one comparator step at a time. After reset a clearing pass writes all
//  MAX_NODES*LEVELS (10240) table rows, one per cycle, with s_tready low;
//  config writes are taken meanwhile.
//  A finished query result sits in the output register; the sequencer only
//  waits if a prior result is still not taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tree_path_min_query
    import tpmq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,    // node_a[9:0], node_b[19:10], edge_weight[39:20]
    input  logic [1:0]       s_tuser,    // opcode[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,    // path_minimum[19:0], zero fill
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data
);

    typedef enum logic [23:0] {
        ST_IDLE    = 24'h000001,
        ST_CLEAR   = 24'h000002,
        ST_LD_RD   = 24'h000004,
        ST_LD_WR   = 24'h000008,
        ST_B_RD0   = 24'h000010,
        ST_B_RD1   = 24'h000020,
        ST_B_WR    = 24'h000040,
        ST_Q_DA    = 24'h000080,
        ST_Q_DB    = 24'h000100,
        ST_Q_SWAP  = 24'h000200,
        ST_L1_ANC  = 24'h000400,
        ST_L1_DEP  = 24'h000800,
        ST_L1_CMP  = 24'h001000,
        ST_L2_ANCU = 24'h002000,
        ST_L2_ANCV = 24'h004000,
        ST_L2_CMP  = 24'h008000,
        ST_L2_PAR  = 24'h010000,
        ST_L2_PGET = 24'h020000,
        ST_PD_RD   = 24'h040000,
        ST_PD_GET  = 24'h080000,
        ST_C_ANC   = 24'h100000,
        ST_C_DEP   = 24'h200000,
        ST_C_CMP   = 24'h400000,
        ST_Q_OUT   = 24'h800000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  node_count_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [NODE_W-1:0] a_reg, b_reg, u_reg, v_reg, atmp_reg, p_reg, bj_reg;
    logic [W_W-1:0]    w_reg, mtmp_reg, m_reg, out_reg;
    logic [DEP_W-1:0]  du_reg, dv_reg, pd_reg;
    logic [LVL_W-1:0]  i_reg, bi_reg;
    logic              side_reg, m_valid_reg;

    tab_wr_t           wr;
    tab_rd_t           rd;
    logic [NODE_W-1:0] anc_rdata;
    logic [W_W-1:0]    min_rdata;
    logic [DEP_W-1:0]  dep_rdata;

    // live node and level counts from the config register
    logic [CNT_W-1:0]  n_live;
    logic [LVL_W-1:0]  lv_live, top;
    int                bit_len;

    always_comb begin
        if (node_count_reg == '0) begin
            n_live = CNT_W'(1);
        end else if (node_count_reg > CNT_W'(MAX_NODES)) begin
            n_live = CNT_W'(MAX_NODES);
        end else begin
            n_live = node_count_reg;
        end
        bit_len = 0;
        for (int k = 0; k < CNT_W; k++) begin
            if (n_live[k]) bit_len = k + 1;
        end
        if (bit_len > LEVELS) bit_len = LEVELS;
        lv_live = LVL_W'(bit_len);
        top     = lv_live - LVL_W'(1);
    end

    logic              s_fire;
    logic [NODE_W-1:0] in_a, in_b;
    logic              bj_last, bi_last, l1_take, c_take;
    logic [NODE_W-1:0] u_l1;
    logic              out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign in_a     = NODE_W'(s_tdata[9:0]);
    assign in_b     = NODE_W'(s_tdata[19:10]);
    assign bj_last  = (CNT_W'(bj_reg) + CNT_W'(1)) >= n_live;
    assign bi_last  = (bi_reg + LVL_W'(1)) >= lv_live;
    assign l1_take  = dep_rdata >= dv_reg;
    assign u_l1     = l1_take ? atmp_reg : u_reg;
    assign c_take   = dep_rdata >= pd_reg;
    assign out_free = !m_valid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        OP_LOAD:  if (in_a != '0) state_next = ST_LD_RD;
                        OP_BUILD: if (lv_live > LVL_W'(1) && n_live > CNT_W'(1))
                                      state_next = ST_B_RD0;
                        OP_QUERY: state_next = ST_Q_DA;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:   if (clr_reg == ADDR_W'(TAB_DEPTH - 1)) state_next = ST_IDLE;
            ST_LD_RD:   state_next = ST_LD_WR;
            ST_LD_WR:   state_next = ST_IDLE;
            ST_B_RD0:   state_next = ST_B_RD1;
            ST_B_RD1:   state_next = ST_B_WR;
            ST_B_WR:    state_next = (bj_last && bi_last) ? ST_IDLE : ST_B_RD0;
            ST_Q_DA:    state_next = ST_Q_DB;
            ST_Q_DB:    state_next = ST_Q_SWAP;
            ST_Q_SWAP:  state_next = ST_L1_ANC;
            ST_L1_ANC:  state_next = ST_L1_DEP;
            ST_L1_DEP:  state_next = ST_L1_CMP;
            ST_L1_CMP: begin
                if (i_reg != '0)       state_next = ST_L1_ANC;
                else if (u_l1 == v_reg) state_next = ST_PD_RD;
                else                   state_next = ST_L2_ANCU;
            end
            ST_L2_ANCU: state_next = ST_L2_ANCV;
            ST_L2_ANCV: state_next = ST_L2_CMP;
            ST_L2_CMP:  state_next = (i_reg == '0) ? ST_L2_PAR : ST_L2_ANCU;
            ST_L2_PAR:  state_next = ST_L2_PGET;
            ST_L2_PGET: state_next = ST_PD_RD;
            ST_PD_RD:   state_next = ST_PD_GET;
            ST_PD_GET:  state_next = ST_C_ANC;
            ST_C_ANC:   state_next = ST_C_DEP;
            ST_C_DEP:   state_next = ST_C_CMP;
            ST_C_CMP: begin
                if (i_reg != '0)  state_next = ST_C_ANC;
                else if (side_reg) state_next = ST_Q_OUT;
                else              state_next = ST_C_ANC;
            end
            ST_Q_OUT:   if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // table read addresses
    always_comb begin
        rd = '0;
        unique case (state_reg)
            ST_B_RD0:   rd.tab_addr = tab_index(bj_reg, bi_reg - LVL_W'(1));
            ST_B_RD1:   rd.tab_addr = tab_index(anc_rdata, bi_reg - LVL_W'(1));
            ST_L1_ANC,
            ST_L2_ANCU,
            ST_C_ANC:   rd.tab_addr = tab_index(u_reg, i_reg);
            ST_L2_ANCV: rd.tab_addr = tab_index(v_reg, i_reg);
            ST_L2_PAR:  rd.tab_addr = tab_index(v_reg, '0);
            default:    rd.tab_addr = '0;
        endcase
        unique case (state_reg)
            ST_LD_RD:   rd.dep_addr = b_reg;
            ST_Q_DA:    rd.dep_addr = a_reg;
            ST_Q_DB:    rd.dep_addr = b_reg;
            ST_L1_DEP,
            ST_C_DEP:   rd.dep_addr = anc_rdata;
            ST_PD_RD:   rd.dep_addr = p_reg;
            default:    rd.dep_addr = '0;
        endcase
    end

    // table writes: clearing pass, edge load, lifting build
    always_comb begin
        wr = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                wr.tab_en   = 1'b1;
                wr.tab_addr = clr_reg;
                wr.anc_data = '0;
                wr.min_data = EMPTY_PATH;
                wr.dep_en   = clr_reg < ADDR_W'(MAX_NODES);
                wr.dep_addr = NODE_W'(clr_reg);
                wr.dep_data = '0;
            end
            ST_LD_WR: begin
                wr.tab_en   = 1'b1;
                wr.tab_addr = tab_index(a_reg, '0);
                wr.anc_data = b_reg;
                wr.min_data = w_reg;
                wr.dep_en   = 1'b1;
                wr.dep_addr = a_reg;
                wr.dep_data = dep_rdata + DEP_W'(1);
            end
            ST_B_WR: begin
                wr.tab_en   = 1'b1;
                wr.tab_addr = tab_index(bj_reg, bi_reg);
                wr.anc_data = anc_rdata;
                wr.min_data = (mtmp_reg < min_rdata) ? mtmp_reg : min_rdata;
            end
            default: wr = '0;
        endcase
    end

    tpmq_tables u_tables (
        .aclk      (aclk),
        .wr        (wr),
        .rd        (rd),
        .anc_rdata (anc_rdata),
        .min_rdata (min_rdata),
        .dep_rdata (dep_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            node_count_reg <= CNT_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + ADDR_W'(1);
            if (cfg_wr_en) node_count_reg <= cfg_wr_data;
            if (state_reg == ST_Q_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                a_reg  <= in_a;
                b_reg  <= in_b;
                w_reg  <= W_W'(s_tdata[39:20]);
                bi_reg <= LVL_W'(1);
                bj_reg <= NODE_W'(1);
            end
            ST_B_RD1: begin
                mtmp_reg <= min_rdata;
            end
            ST_B_WR: begin
                if (bj_last) begin
                    bj_reg <= NODE_W'(1);
                    bi_reg <= bi_reg + LVL_W'(1);
                end else begin
                    bj_reg <= bj_reg + NODE_W'(1);
                end
            end
            ST_Q_DB: du_reg <= dep_rdata;
            ST_Q_SWAP: begin
                // deeper node climbs first
                i_reg <= top;
                if (dep_rdata > du_reg) begin
                    u_reg  <= b_reg;
                    v_reg  <= a_reg;
                    dv_reg <= du_reg;
                end else begin
                    u_reg  <= a_reg;
                    v_reg  <= b_reg;
                    dv_reg <= dep_rdata;
                end
            end
            ST_L1_DEP: atmp_reg <= anc_rdata;
            ST_L1_CMP: begin
                u_reg <= u_l1;
                p_reg <= u_l1;
                i_reg <= (i_reg == '0) ? top : i_reg - LVL_W'(1);
            end
            ST_L2_ANCV: atmp_reg <= anc_rdata;
            ST_L2_CMP: begin
                if (atmp_reg != anc_rdata) begin
                    u_reg <= atmp_reg;
                    v_reg <= anc_rdata;
                end
                if (i_reg != '0) i_reg <= i_reg - LVL_W'(1);
            end
            ST_L2_PGET: p_reg <= anc_rdata;
            ST_PD_GET: begin
                pd_reg   <= dep_rdata;
                u_reg    <= a_reg;
                i_reg    <= top;
                m_reg    <= EMPTY_PATH;
                side_reg <= 1'b0;
            end
            ST_C_DEP: begin
                atmp_reg <= anc_rdata;
                mtmp_reg <= min_rdata;
            end
            ST_C_CMP: begin
                if (c_take) begin
                    if (mtmp_reg < m_reg) m_reg <= mtmp_reg;
                end
                if (i_reg != '0) begin
                    i_reg <= i_reg - LVL_W'(1);
                    if (c_take) u_reg <= atmp_reg;
                end else begin
                    // second endpoint climbs next
                    side_reg <= 1'b1;
                    u_reg    <= b_reg;
                    i_reg    <= top;
                end
            end
            ST_Q_OUT: if (out_free) out_reg <= m_reg;
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, out_reg};

endmodule

>>> rtl/tpmq_checker.sv
// ---------------------------------------------------------------------------
// tpmq_checker
// Port-level checks for the path-minimum block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tree_path_min_query_macros.svh"

module tpmq_checker
    import tpmq_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [1:0]       s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [23:0]      m_tdata
);

    logic q_fire;
    assign q_fire = s_tvalid && s_tready && (s_tuser == OP_QUERY);

    `TPMQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat dropped or changed while stalled")
    `TPMQ_ASSERT_NOW(a_out_fill, aclk, aresetn, m_tvalid, m_tdata[23:20] == 4'b0, "result beat fill bits not zero")
    `TPMQ_ASSERT_NEXT(a_query_busy, aclk, aresetn, q_fire, !s_tready, "input taken while a query is in work")

endmodule

bind tree_path_min_query tpmq_checker u_tpmq_checker (.*);

>>> verif/tb_tree_path_min_query.sv
// ---------------------------------------------------------------------------
// tb_tree_path_min_query
// Self-checking bench for the binary-lifting tree path minimum block.
// Trees are loaded edge by edge, the lifting tables are built and path
// queries are checked against a predictor that keeps its own copy of the
// ancestor, minimum and depth tables. Sender and receiver idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tree_path_min_query;
    import tpmq_pkg::*;

    // Unused opcode, ignored by the block.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Cycle cap: covers the clearing pass, full-size builds and stalls.
    localparam int CYCLE_LIMIT = 1000000;
    // Drain margin: longer than a query, a load or a short build.
    localparam int DRAIN_CYCLES = 400;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata = '0;     // node_a[9:0], node_b[19:10], edge_weight[39:20]
    logic [1:0]       s_tuser = '0;     // opcode[1:0]
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [23:0]      m_tdata;          // path_minimum[19:0], zero fill
    logic             cfg_wr_en = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;

    tree_path_min_query u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // -----------------------------------------------------------------------
    // Predictor state: a private copy of the block's tables and node count.
    // -----------------------------------------------------------------------
    logic [NODE_W-1:0] anc_tab [0:TAB_DEPTH-1];
    logic [W_W-1:0]    min_tab [0:TAB_DEPTH-1];
    logic [DEP_W-1:0]  dep_tab [0:MAX_NODES-1];
    logic [CNT_W-1:0]  node_count_q;

    logic [W_W-1:0] exp_minimum_q [$];   // path minimums still owed by the block

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_left      = 0;   // long receiver hold-off, counted down below
    int  fail_cnt       = 0;
    int  cycle_cnt      = 0;

    function automatic int live_nodes();
        int n;
        n = int'(node_count_q);
        if (n < 1) n = 1;
        if (n > MAX_NODES) n = MAX_NODES;
        return n;
    endfunction

    function automatic int live_levels();
        int n;
        int bits;
        n = live_nodes();
        bits = 0;
        while (n != 0) begin
            n = n >> 1;
            bits++;
        end
        return (bits > LEVELS) ? LEVELS : bits;
    endfunction

    function automatic logic [NODE_W-1:0] hop(logic [NODE_W-1:0] node, int lvl);
        return anc_tab[node * LEVELS + lvl];
    endfunction

    function automatic logic [NODE_W-1:0] meet_node(logic [NODE_W-1:0] a,
                                                    logic [NODE_W-1:0] b, int top);
        logic [NODE_W-1:0] u;
        logic [NODE_W-1:0] v;
        logic [NODE_W-1:0] t;
        u = a;
        v = b;
        if (dep_tab[v] > dep_tab[u]) begin
            t = u; u = v; v = t;
        end
        // lift the deeper endpoint to the other's depth
        for (int i = top; i >= 0; i--) begin
            t = hop(u, i);
            if (dep_tab[t] >= dep_tab[v]) u = t;
        end
        if (u == v) return u;
        for (int i = top; i >= 0; i--) begin
            if (hop(u, i) != hop(v, i)) begin
                t = hop(u, i);
                v = hop(v, i);
                u = t;
            end
        end
        return hop(v, 0);
    endfunction

    function automatic logic [W_W-1:0] climb_minimum(logic [NODE_W-1:0] start,
                                                     logic [DEP_W-1:0] stop_dep, int top);
        logic [W_W-1:0]    m;
        logic [NODE_W-1:0] u;
        logic [NODE_W-1:0] t;
        m = EMPTY_PATH;
        u = start;
        for (int i = top; i >= 0; i--) begin
            t = hop(u, i);
            if (dep_tab[t] >= stop_dep) begin
                if (min_tab[u * LEVELS + i] < m) m = min_tab[u * LEVELS + i];
                u = t;
            end
        end
        return m;
    endfunction

    // Apply one accepted beat to the predictor; queries queue a result.
    task automatic predict_beat(logic [1:0] op, logic [NODE_W-1:0] a,
                                logic [NODE_W-1:0] b, logic [W_W-1:0] w);
        int n;
        int lv;
        int top;
        int here;
        logic [NODE_W-1:0] mid;
        logic [NODE_W-1:0] p;
        logic [W_W-1:0] m1;
        logic [W_W-1:0] m2;
        case (op)
            OP_LOAD: begin
                if (a != 0) begin
                    anc_tab[a * LEVELS] = b;
                    min_tab[a * LEVELS] = w;
                    dep_tab[a] = dep_tab[b] + 1'b1;
                end
            end
            OP_BUILD: begin
                n = live_nodes();
                lv = live_levels();
                for (int i = 1; i < lv; i++) begin
                    for (int j = 1; j < n; j++) begin
                        mid = hop(NODE_W'(j), i - 1);
                        here = j * LEVELS + i;
                        anc_tab[here] = hop(mid, i - 1);
                        min_tab[here] = (min_tab[here - 1] < min_tab[mid * LEVELS + i - 1])
                                        ? min_tab[here - 1] : min_tab[mid * LEVELS + i - 1];
                    end
                end
            end
            OP_QUERY: begin
                top = live_levels() - 1;
                p = meet_node(a, b, top);
                m1 = climb_minimum(a, dep_tab[p], top);
                m2 = climb_minimum(b, dep_tab[p], top);
                exp_minimum_q.push_back((m1 < m2) ? m1 : m2);
            end
            default: ;  // unused opcode: no effect
        endcase
    endtask

    // -----------------------------------------------------------------------
    // Beat driver: inputs change on the falling edge, acceptance is seen at
    // the rising edge. Called and returns on a falling edge.
    // -----------------------------------------------------------------------
    task automatic send_beat(logic [1:0] op, logic [NODE_W-1:0] a,
                             logic [NODE_W-1:0] b, logic [W_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {w, b, a};
        do @(posedge aclk); while (!s_tready);
        predict_beat(op, a, b, w);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Register write; only called with nothing in flight.
    task automatic write_node_count(logic [CNT_W-1:0] val);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        node_count_q = val;
    endtask

    // Let all owed results arrive, then give silent work (builds) time to end.
    task automatic wait_drained();
        wait (exp_minimum_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [W_W-1:0] pick_weight();
        case ($urandom_range(9))
            0: return '0;
            1: return W_W'(1000000);
            2: return '1;                 // above range, stored as given
            default: return W_W'($urandom_range(1000000));
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when requested.
    // -----------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result check against the oldest owed path minimum.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_minimum_q.size() == 0) begin
                $error("unexpected result beat: path_minimum=%0d", m_tdata[19:0]);
                fail_cnt++;
            end else begin
                if (m_tdata[19:0] !== exp_minimum_q[0]) begin
                    $error("path_minimum mismatch: expected %0d, actual %0d",
                           exp_minimum_q[0], m_tdata[19:0]);
                    fail_cnt++;
                end
                void'(exp_minimum_q.pop_front());
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Small hand-made tree: root load, weight extremes, unused opcode,
    // query before build, same-node query, root endpoints.
    task automatic test_directed();
        write_node_count(8);
        send_beat(OP_LOAD, 0, 5, 7);                    // root load is ignored
        send_beat(OP_LOAD, 1, 0, W_W'(1000000));
        send_beat(OP_LOAD, 2, 0, 0);
        send_beat(OP_LOAD, 3, 1, 5);
        send_beat(OP_LOAD, 4, 3, '1);
        send_beat(OP_LOAD, 5, 2, 9);
        send_beat(OP_LOAD, 6, 5, 77);
        send_beat(OP_LOAD, 7, 4, 123);
        send_beat(OP_QUERY, 7, 6, 0);                   // tables not built yet
        send_beat(OP_UNUSED, 3, 2, 1);
        send_beat(OP_BUILD, 0, 0, 0);
        send_beat(OP_QUERY, 4, 5, 0);
        send_beat(OP_QUERY, 3, 3, 0);                   // empty path
        send_beat(OP_QUERY, 0, 7, 0);
        send_beat(OP_QUERY, 7, 0, 0);
        send_beat(OP_QUERY, 6, 7, 0);
        send_beat(OP_QUERY, 1023, 1023, 0);
        send_beat(OP_QUERY, 1023, 5, '1);
        wait_drained();
    endtask

    // One tree of n nodes in index order, built, then queried. A malformed
    // tree gets stray beats of random opcode, builds included, among its queries.
    task automatic test_random_tree(int n, int nq, bit malformed);
        int par;
        int a;
        int b;
        write_node_count(CNT_W'(n));
        for (int j = 1; j < n; j++) begin
            par = ($urandom_range(2) == 0) ? j - 1 : $urandom_range(j - 1);
            send_beat(OP_LOAD, NODE_W'(j), NODE_W'(par), pick_weight());
        end
        send_beat(OP_BUILD, 0, 0, 0);
        for (int k = 0; k < nq; k++) begin
            if (malformed && $urandom_range(3) == 0)
                send_beat(2'($urandom_range(3)), NODE_W'($urandom_range(1023)),
                          NODE_W'($urandom_range(1023)), pick_weight());
            a = $urandom_range(n - 1);
            b = ($urandom_range(5) == 0) ? a : $urandom_range(n - 1);
            send_beat(OP_QUERY, NODE_W'(a), NODE_W'(b), W_W'($urandom));
        end
        wait_drained();
    endtask

    // Node count at its extremes, including the full-size build.
    task automatic test_node_count_extremes();
        int par;
        write_node_count(0);                            // acts as one node
        send_beat(OP_BUILD, 0, 0, 0);
        send_beat(OP_QUERY, 1, 2, 0);
        wait_drained();
        write_node_count(1);
        send_beat(OP_LOAD, 1, 0, 42);
        send_beat(OP_BUILD, 0, 0, 0);
        send_beat(OP_QUERY, 1, 0, 0);
        wait_drained();
        write_node_count(CNT_W'(MAX_NODES));
        for (int j = 1000; j < MAX_NODES; j++) begin
            par = (j == 1000) ? 0 : $urandom_range(1000, j - 1);
            send_beat(OP_LOAD, NODE_W'(j), NODE_W'(par), pick_weight());
        end
        send_beat(OP_BUILD, 0, 0, 0);
        for (int k = 0; k < 8; k++)
            send_beat(OP_QUERY, NODE_W'($urandom_range(1000, 1023)),
                      NODE_W'($urandom_range(1000, 1023)), 0);
        wait_drained();
        write_node_count('1);                           // above range, clamps
        send_beat(OP_LOAD, 1023, 1022, 3);
        send_beat(OP_BUILD, 0, 0, 0);
        send_beat(OP_QUERY, 1023, 1001, 0);
        send_beat(OP_QUERY, 512, 1023, 0);
        wait_drained();
    endtask

    // Receiver holds off while queries keep coming, so the input backs up.
    task automatic test_output_backpressure();
        write_node_count(12);
        for (int j = 1; j < 12; j++)
            send_beat(OP_LOAD, NODE_W'(j), NODE_W'($urandom_range(j - 1)), pick_weight());
        send_beat(OP_BUILD, 0, 0, 0);
        hold_left = 3000;
        for (int k = 0; k < 12; k++)
            send_beat(OP_QUERY, NODE_W'($urandom_range(11)), NODE_W'($urandom_range(11)), 0);
        wait_drained();
    endtask

    // Random trees under each idling mode.
    task automatic test_random_traffic();
        int sizes;
        for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct  = (mode == 1 || mode == 3) ? ((mode == 3) ? 21 : 56) : 0;
            recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 21 : 56) : 0;
            for (int t = 0; t < 5; t++) begin
                sizes = ($urandom_range(4) == 0) ? $urandom_range(40, 70)
                                                 : $urandom_range(2, 20);
                test_random_tree(sizes, $urandom_range(6, 14), $urandom_range(3) == 0);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        for (int k = 0; k < TAB_DEPTH; k++) begin
            anc_tab[k] = '0;
            min_tab[k] = EMPTY_PATH;
        end
        for (int k = 0; k < MAX_NODES; k++) dep_tab[k] = '0;
        node_count_q = 1;

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_node_count_extremes();
        test_output_backpressure();
        test_random_traffic();

        wait_drained();
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/tpmq_pkg.sv
rtl/tpmq_tables.sv
rtl/tree_path_min_query.sv
rtl/tpmq_checker.sv
verif/tb_tree_path_min_query.sv
